FILE: hdl/primitive_to_triangle_expander_unit_macros.svh
// Assertion macros for the primitive to triangle expander.
// Used by modules that hold concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef PRIMITIVE_TO_TRIANGLE_EXPANDER_UNIT_MACROS_SVH
`define PRIMITIVE_TO_TRIANGLE_EXPANDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptx assertion failed");

// Next-cycle implication, disabled during reset.
`define PTX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptx assertion failed");

`endif

FILE: hdl/ptx_pkg.sv
// Package for the primitive to triangle expander: types, constants and helpers.
// No dependencies; imported by every module of the block.
`default_nettype none
package ptx_pkg;
    localparam int CoordW      = 24;
    localparam int ColorW      = 32;
    localparam int AngleW      = 16;
    localparam int ThickW      = 23;
    localparam int QueueDepth  = 2;
    localparam int CordicSteps = 16;
    localparam int SqrtSteps   = 30;
    localparam int DivSteps    = 53;
    localparam int MulSteps    = 4;

    localparam logic signed [33:0] CordicGain  = 34'sd652032874;
    localparam logic signed [24:0] QuarterTurn = 25'sd4194304;
    localparam logic signed [24:0] HalfTurn    = 25'sd8388608;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic [ColorW-1:0]        t_color;

    typedef enum logic [1:0] {
        CMD_QUAD = 2'd0,
        CMD_ROTQ = 2'd1,
        CMD_TRI  = 2'd2,
        CMD_LINE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        FS_IDLE, FS_SIMPLE, FS_CORDIC, FS_MUL, FS_RCORN,
        FS_SQRT, FS_DIV, FS_LCORN, FS_PUSH
    } t_fstate;

    typedef struct packed {
        logic           is_tri;
        t_coord [3:0]   px;
        t_coord [3:0]   py;
        t_color         color;
    } t_prim;

    typedef struct packed {
        logic full;
        logic nempty;
    } t_qstat;

    function automatic t_coord sat_coord(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic [24:0] cordic_atan(input logic [3:0] i);
        unique case (i)
            4'd0:  return 25'd2097152;
            4'd1:  return 25'd1238021;
            4'd2:  return 25'd654136;
            4'd3:  return 25'd332050;
            4'd4:  return 25'd166669;
            4'd5:  return 25'd83416;
            4'd6:  return 25'd41718;
            4'd7:  return 25'd20860;
            4'd8:  return 25'd10430;
            4'd9:  return 25'd5215;
            4'd10: return 25'd2608;
            4'd11: return 25'd1304;
            4'd12: return 25'd652;
            4'd13: return 25'd326;
            4'd14: return 25'd163;
            4'd15: return 25'd81;
            default: return 25'd0;
        endcase
    endfunction

    // Corner order of two triangles: p1,p2,p3,p1,p3,p4.
    function automatic logic [1:0] quad_corner(input logic [2:0] k);
        unique case (k)
            3'd0: return 2'd0;
            3'd1: return 2'd1;
            3'd2: return 2'd2;
            3'd3: return 2'd0;
            3'd4: return 2'd2;
            3'd5: return 2'd3;
            default: return 2'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: hdl/ptx_front.sv
// Front end: accepts primitives and computes their four corners.
// Depends on ptx_pkg; holds the CORDIC, square root and divider sequencer.
`default_nettype none
module ptx_front
    import ptx_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_command,
    input  wire t_coord            i_x0,
    input  wire t_coord            i_y0,
    input  wire t_coord            i_x1,
    input  wire t_coord            i_y1,
    input  wire t_coord            i_x2,
    input  wire t_coord            i_y2,
    input  wire logic [AngleW-1:0] i_angle,
    input  wire logic [ThickW-1:0] i_thickness,
    input  wire t_color            i_color,
    input  wire t_qstat            i_qstat,
    output logic                   o_busy,
    output logic                   o_push,
    output t_prim                  o_prim
);
    t_fstate r_state, n_state;
    t_cmd    r_cmd;
    t_coord  r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [ThickW-1:0] r_thk;
    t_color  r_col;
    logic signed [33:0] r_cx, r_cy;
    logic signed [24:0] r_z;
    logic               r_neg;
    logic [5:0]         r_it;
    logic signed [59:0] r_pr [4];
    logic signed [24:0] r_dx, r_dy;
    logic [59:0]        r_sv;
    logic [31:0]        r_rem;
    logic [29:0]        r_root;
    logic [52:0]        r_qx, r_qy;
    logic [29:0]        r_rx, r_ry;
    t_prim              r_out;

    logic               acc, zero_line, neg_f;
    logic signed [24:0] z_in, z_f, dx_in, dy_in, at, abs_dx, abs_dy;
    logic signed [33:0] sh_x, sh_y, c_val, s_val, m_b;
    logic signed [24:0] m_a;
    logic signed [59:0] m_p, dsum;
    logic [33:0]        rs, tr;
    logic               ge, gx, gy;
    logic [30:0]        dsx, dsy, lw;
    logic signed [63:0] bx, by, pa, pb, pc, pd, qxs, qys;

    assign acc       = i_start && (r_state == FS_IDLE);
    assign dx_in     = 25'(i_x1) - 25'(i_x0);
    assign dy_in     = 25'(i_y1) - 25'(i_y0);
    assign zero_line = (i_x1 == i_x0) && (i_y1 == i_y0);

    always_comb begin
        z_in  = 25'(signed'({i_angle, 8'h00}));
        z_f   = z_in;
        neg_f = 1'b0;
        if (z_in > QuarterTurn) begin
            z_f   = z_in - HalfTurn;
            neg_f = 1'b1;
        end else if (z_in < -QuarterTurn) begin
            z_f   = z_in + HalfTurn;
            neg_f = 1'b1;
        end
    end

    assign sh_x  = r_cx >>> r_it[3:0];
    assign sh_y  = r_cy >>> r_it[3:0];
    assign at    = signed'(cordic_atan(r_it[3:0]));
    assign c_val = r_neg ? -r_cx : r_cx;
    assign s_val = r_neg ? -r_cy : r_cy;
    assign abs_dx = r_dx[24] ? -r_dx : r_dx;
    assign abs_dy = r_dy[24] ? -r_dy : r_dy;

    always_comb begin
        m_a = 25'sd0;
        m_b = 34'sd0;
        if (r_cmd == CMD_ROTQ) begin
            case (r_it[1:0])
                2'd0: begin m_a = 25'(r_x1); m_b = c_val; end
                2'd1: begin m_a = 25'(r_x1); m_b = s_val; end
                2'd2: begin m_a = 25'(r_y1); m_b = c_val; end
                default: begin m_a = 25'(r_y1); m_b = s_val; end
            endcase
        end else begin
            case (r_it[1:0])
                2'd0: begin m_a = r_dx; m_b = 34'(r_dx); end
                2'd1: begin m_a = r_dy; m_b = 34'(r_dy); end
                2'd2: begin m_a = abs_dy; m_b = 34'(signed'({1'b0, r_thk})); end
                default: begin m_a = abs_dx; m_b = 34'(signed'({1'b0, r_thk})); end
            endcase
        end
    end

    assign m_p  = 60'(m_a) * 60'(m_b);
    assign dsum = r_pr[0] + r_pr[1];

    assign rs = {r_rem, r_sv[59:58]};
    assign tr = {2'b00, r_root, 2'b01};
    assign ge = (rs >= tr);

    assign lw  = {1'b0, r_root};
    assign dsx = {r_rx, r_qx[52]};
    assign dsy = {r_ry, r_qy[52]};
    assign gx  = (dsx >= lw);
    assign gy  = (dsy >= lw);

    assign bx = (((64'(r_x0) <<< 1) + 64'(r_x1)) <<< 30) + 64'sd1073741824;
    assign by = (((64'(r_y0) <<< 1) + 64'(r_y1)) <<< 30) + 64'sd1073741824;
    assign pa = 64'(r_pr[0]);
    assign pb = 64'(r_pr[1]);
    assign pc = 64'(r_pr[2]);
    assign pd = 64'(r_pr[3]);
    assign qxs = !r_dy[24] ? -signed'(64'(r_qx)) : signed'(64'(r_qx));
    assign qys = r_dx[24] ? -signed'(64'(r_qy)) : signed'(64'(r_qy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_busy  = (r_state != FS_IDLE);
        unique case (r_state)
            FS_IDLE: begin
                if (acc) begin
                    unique case (t_cmd'(i_command))
                        CMD_QUAD, CMD_TRI: n_state = FS_SIMPLE;
                        CMD_ROTQ:          n_state = FS_CORDIC;
                        CMD_LINE:          n_state = zero_line ? FS_IDLE : FS_MUL;
                        default:           n_state = FS_IDLE;
                    endcase
                end
            end
            FS_SIMPLE: n_state = FS_PUSH;
            FS_CORDIC: begin
                if (r_it == 6'(CordicSteps - 1)) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: begin
                if (r_it == 6'(MulSteps - 1)) begin
                    n_state = (r_cmd == CMD_ROTQ) ? FS_RCORN : FS_SQRT;
                end
            end
            FS_RCORN: n_state = FS_PUSH;
            FS_SQRT: begin
                if (r_it == 6'(SqrtSteps - 1)) begin
                    n_state = FS_DIV;
                end
            end
            FS_DIV: begin
                if (r_it == 6'(DivSteps)) begin
                    n_state = FS_LCORN;
                end
            end
            FS_LCORN: n_state = FS_PUSH;
            FS_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                if (acc) begin
                    r_cmd <= t_cmd'(i_command);
                    r_x0  <= i_x0;
                    r_y0  <= i_y0;
                    r_x1  <= i_x1;
                    r_y1  <= i_y1;
                    r_x2  <= i_x2;
                    r_y2  <= i_y2;
                    r_thk <= i_thickness;
                    r_col <= i_color;
                    r_dx  <= dx_in;
                    r_dy  <= dy_in;
                    r_cx  <= CordicGain;
                    r_cy  <= 34'sd0;
                    r_z   <= z_f;
                    r_neg <= neg_f;
                    r_it  <= 6'd0;
                end
            end
            FS_SIMPLE: begin
                r_out.color <= r_col;
                if (r_cmd == CMD_TRI) begin
                    r_out.is_tri <= 1'b1;
                    r_out.px     <= {r_x2, r_x2, r_x1, r_x0};
                    r_out.py     <= {r_y2, r_y2, r_y1, r_y0};
                end else begin
                    r_out.is_tri <= 1'b0;
                    r_out.px[0]  <= r_x0;
                    r_out.px[1]  <= sat_coord(64'(r_x0) + 64'(r_x1));
                    r_out.px[2]  <= sat_coord(64'(r_x0) + 64'(r_x1));
                    r_out.px[3]  <= r_x0;
                    r_out.py[0]  <= r_y0;
                    r_out.py[1]  <= r_y0;
                    r_out.py[2]  <= sat_coord(64'(r_y0) + 64'(r_y1));
                    r_out.py[3]  <= sat_coord(64'(r_y0) + 64'(r_y1));
                end
            end
            FS_CORDIC: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_z  <= r_z - at;
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_z  <= r_z + at;
                end
                r_it <= (r_it == 6'(CordicSteps - 1)) ? 6'd0 : r_it + 6'd1;
            end
            FS_MUL: begin
                r_pr[r_it[1:0]] <= m_p;
                r_it   <= (r_it == 6'(MulSteps - 1)) ? 6'd0 : r_it + 6'd1;
                r_sv   <= {dsum[49:0], 10'b0};
                r_rem  <= 32'd0;
                r_root <= 30'd0;
            end
            FS_RCORN: begin
                r_out.is_tri <= 1'b0;
                r_out.color  <= r_col;
                r_out.px[0]  <= sat_coord((bx - pa + pd) >>> 31);
                r_out.py[0]  <= sat_coord((by - pb - pc) >>> 31);
                r_out.px[1]  <= sat_coord((bx + pa + pd) >>> 31);
                r_out.py[1]  <= sat_coord((by + pb - pc) >>> 31);
                r_out.px[2]  <= sat_coord((bx + pa - pd) >>> 31);
                r_out.py[2]  <= sat_coord((by + pb + pc) >>> 31);
                r_out.px[3]  <= sat_coord((bx - pa - pd) >>> 31);
                r_out.py[3]  <= sat_coord((by - pb + pc) >>> 31);
            end
            FS_SQRT: begin
                r_rem  <= ge ? 32'(rs - tr) : 32'(rs);
                r_root <= {r_root[28:0], ge};
                r_sv   <= {r_sv[57:0], 2'b00};
                r_it   <= (r_it == 6'(SqrtSteps - 1)) ? 6'd0 : r_it + 6'd1;
            end
            FS_DIV: begin
                if (r_it == 6'd0) begin
                    r_qx <= 53'({r_pr[2][47:0], 4'b0}) + 53'(r_root[29:1]);
                    r_qy <= 53'({r_pr[3][47:0], 4'b0}) + 53'(r_root[29:1]);
                    r_rx <= 30'd0;
                    r_ry <= 30'd0;
                end else begin
                    r_rx <= gx ? 30'(dsx - lw) : dsx[29:0];
                    r_ry <= gy ? 30'(dsy - lw) : dsy[29:0];
                    r_qx <= {r_qx[51:0], gx};
                    r_qy <= {r_qy[51:0], gy};
                end
                r_it <= (r_it == 6'(DivSteps)) ? 6'd0 : r_it + 6'd1;
            end
            FS_LCORN: begin
                r_out.is_tri <= 1'b0;
                r_out.color  <= r_col;
                r_out.px[0]  <= sat_coord(64'(r_x0) - qxs);
                r_out.py[0]  <= sat_coord(64'(r_y0) - qys);
                r_out.px[1]  <= sat_coord(64'(r_x0) + qxs);
                r_out.py[1]  <= sat_coord(64'(r_y0) + qys);
                r_out.px[2]  <= sat_coord(64'(r_x1) + qxs);
                r_out.py[2]  <= sat_coord(64'(r_y1) + qys);
                r_out.px[3]  <= sat_coord(64'(r_x1) - qxs);
                r_out.py[3]  <= sat_coord(64'(r_y1) - qys);
            end
            default: begin
            end
        endcase
    end

    assign o_prim = r_out;
endmodule
`default_nettype wire

FILE: hdl/ptx_queue.sv
// Short queue of expanded primitives between the front and back ends.
// Depends on ptx_pkg for the entry and status types.
`default_nettype none
module ptx_queue
    import ptx_pkg::*;
#(
    parameter int QDepth = QueueDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_prim i_data,
    input  wire logic  i_pop,
    output t_prim      o_data,
    output t_qstat     o_stat
);
    localparam int PtrW = $clog2(QDepth);
    localparam int CntW = $clog2(QDepth + 1);

    t_prim             r_mem [QDepth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [CntW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PtrW'(QDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PtrW'(QDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data        = r_mem[r_rp];
    assign o_stat.full   = (r_cnt == CntW'(QDepth));
    assign o_stat.nempty = (r_cnt != '0);
endmodule
`default_nettype wire

FILE: hdl/ptx_back.sv
// Back end: walks the corners of one queued primitive and sends its vertices.
// Depends on ptx_pkg; pops the next primitive on the last vertex of the current one.
`default_nettype none
module ptx_back
    import ptx_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_prim i_data,
    input  wire t_qstat i_qstat,
    output logic       o_pop,
    output logic       o_strobe,
    output t_coord     o_vx,
    output t_coord     o_vy,
    output t_color     o_vcolor,
    output logic       o_last
);
    logic       r_act;
    t_prim      r_ent;
    logic [2:0] r_k;
    logic       last_now;
    logic [1:0] idx;

    assign last_now = r_act && (r_k == (r_ent.is_tri ? 3'd2 : 3'd5));
    assign o_pop    = i_qstat.nempty && (!r_act || last_now);
    assign idx      = r_ent.is_tri ? r_k[1:0] : quad_corner(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end else begin
            o_strobe <= r_act;
            o_last   <= last_now;
            if (o_pop) begin
                r_act <= 1'b1;
                r_k   <= 3'd0;
                r_ent <= i_data;
            end else if (last_now) begin
                r_act <= 1'b0;
            end else if (r_act) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_vx     <= r_ent.px[idx];
        o_vy     <= r_ent.py[idx];
        o_vcolor <= r_ent.color;
    end
endmodule
`default_nettype wire

FILE: hdl/primitive_to_triangle_expander_unit.sv
// Quads and triangles pass the simple state; rotated quads the CORDIC, multiply and
// corner states; thick lines the multiply, 30-step square root, 53-step dividers and
// corner states. The front end takes a new primitive only when idle and waits while
// the queue is full. Vertices leave one per cycle, no stall.
// Synchronous active-low reset clears the sequencer, queue and output strobe.
`default_nettype none
`include "primitive_to_triangle_expander_unit_macros.svh"
module primitive_to_triangle_expander_unit
    import ptx_pkg::*;
#(
    parameter int QDepth = QueueDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_command,
    input  wire t_coord            i_x0,
    input  wire t_coord            i_y0,
    input  wire t_coord            i_x1,
    input  wire t_coord            i_y1,
    input  wire t_coord            i_x2,
    input  wire t_coord            i_y2,
    input  wire logic [AngleW-1:0] i_angle,
    input  wire logic [ThickW-1:0] i_thickness,
    input  wire t_color            i_color,
    output logic                   o_strobe,
    output t_coord                 o_vx,
    output t_coord                 o_vy,
    output t_color                 o_vcolor,
    output logic                   o_last
);
    logic   q_push, q_pop;
    t_prim  q_in, q_out;
    t_qstat q_stat;

    ptx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_x0        (i_x0),
        .i_y0        (i_y0),
        .i_x1        (i_x1),
        .i_y1        (i_y1),
        .i_x2        (i_x2),
        .i_y2        (i_y2),
        .i_angle     (i_angle),
        .i_thickness (i_thickness),
        .i_color     (i_color),
        .i_qstat     (q_stat),
        .o_busy      (busy),
        .o_push      (q_push),
        .o_prim      (q_in)
    );

    ptx_queue #(.QDepth(QDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    ptx_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (q_out),
        .i_qstat  (q_stat),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_vx     (o_vx),
        .o_vy     (o_vy),
        .o_vcolor (o_vcolor),
        .o_last   (o_last)
    );

    `PTX_ASSERT_IMP(a_push_room, q_push, !q_stat.full)
    `PTX_ASSERT_IMP(a_pop_data, q_pop, q_stat.nempty)
    `PTX_ASSERT_IMP(a_last_strobe, o_last, o_strobe)
    `PTX_ASSERT_NXT(a_busy_after_start, start && !busy && (i_command != CMD_LINE), busy)
endmodule
`default_nettype wire
